>>> src/cls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cls_pkg: shared types and constants of the cell list builder
// Field widths, command and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package cls_pkg;

    // Field widths of the item and result channels.
    localparam int OPCODE_W = 3;
    localparam int COORD_W  = 12;
    localparam int POS_W    = 12;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 13;

    // Configuration port.
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    // Grid geometry: at most 16 cells per axis, so a flat index fits 12 bits
    // and a cell total (up to 4096) fits 13 bits.
    localparam int FLAT_W  = 12;
    localparam int NCELL_W = 13;
    localparam int NYZ_W   = 9;
    localparam int DIM_W   = 5;
    localparam int AXIS_W  = 4;

    localparam logic [DIM_W-1:0] DIM_MIN   = 5'd1;
    localparam logic [DIM_W-1:0] DIM_MAX   = 5'd16;
    localparam logic [DIM_W-1:0] DIM_RESET = 5'd2;

    // Cycles for the derived geometry registers to follow a register write.
    localparam logic [1:0] CFG_SETTLE = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 2'd2;

    // Commands.
    localparam logic [OPCODE_W-1:0] OP_ADD       = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_BUILD     = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_READ_CELL = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_READ_POS  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR     = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD,
        S_RDCELL,
        S_RDCELL_W,
        S_RDPOS,
        S_RDPOS_W,
        S_ZERO,
        S_CNT_RD,
        S_CNT_FIT,
        S_CNT_WR,
        S_PRE_RD,
        S_PRE_WR,
        S_SCT_RD,
        S_SCT_FIT,
        S_SCT_WR,
        S_BDONE,
        S_RESP
    } t_state;

endpackage
`default_nettype wire

>>> src/cls_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cls_in_if: command channel of the cell list builder
// Valid/ready channel carrying one command with its coordinates and position.
// ----------------------------------------------------------------------------
interface cls_in_if import cls_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [COORD_W-1:0]  cell_x;
    logic signed [COORD_W-1:0]  cell_y;
    logic signed [COORD_W-1:0]  cell_z;
    logic                       skip;
    logic [POS_W-1:0]           position;

    modport source (
        output valid, opcode, cell_x, cell_y, cell_z, skip, position,
        input  ready
    );
    modport sink (
        input  valid, opcode, cell_x, cell_y, cell_z, skip, position,
        output ready
    );
endinterface
`default_nettype wire

>>> src/cls_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cls_out_if: result channel of the cell list builder
// Valid/ready channel carrying one status word and two values.
// ----------------------------------------------------------------------------
interface cls_out_if import cls_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [VALUE_W-1:0]   value_a;
    logic [VALUE_W-1:0]   value_b;

    modport source (
        output valid, status, value_a, value_b,
        input  ready
    );
    modport sink (
        input  valid, status, value_a, value_b,
        output ready
    );
endinterface
`default_nettype wire

>>> src/cell_list_counting_sort.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cell_list_counting_sort: cell list builder with counting sort
// Bins particles on a 3D grid and builds a cell-ordered particle list.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake            Contents
// i_in      in   valid/ready          opcode, cell_x/y/z, skip, position
// o_out     out  valid/ready          status, value_a, value_b
// i_cfg_*   in   write enable only    register index and 5-bit data
//
// A clear or unused command goes straight to the response state; an add
// passes through its add state, and read cell and read position through a
// lookup state and a wait state (no wait state when the lists are not built
// or the position is out of range). A build zeroes every cell count, counts
// the placed particles, forms each cell's start and scatters the particles:
// every step makes at most one access to each of the single-port stores.
// Reset is synchronous; it needs no clearing pass, since the cell counts are
// rebuilt from zero by every build before anything reads them.
// The block takes one command at a time. A finished result waits in the output
// register while the next command is taken; the sequencer holds in its
// response state only when that register is still occupied. After a register
// write the command channel stays not ready until the derived geometry registers follow it.
//
module cell_list_counting_sort
    import cls_pkg::*;
#(
    parameter int MAX_PARTICLES = 4096,
    parameter int MAX_CELLS     = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    cls_in_if.sink                    i_in,
    cls_out_if.source                 o_out,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_wdata
);

    // Particle index, cell index and count widths.
    localparam int PW = $clog2(MAX_PARTICLES);
    localparam int CW = $clog2(MAX_CELLS);
    localparam int NW = $clog2(MAX_PARTICLES + 1);

    // A grid register of zero acts as one, above sixteen as sixteen.
    function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] d;
        if (r < DIM_MIN) begin
            d = DIM_MIN;
        end else if (r > DIM_MAX) begin
            d = DIM_MAX;
        end else begin
            d = r;
        end
        return d;
    endfunction

    // Clamp a signed coordinate to 0..n-1.
    function automatic logic [AXIS_W-1:0] clamp_coord(
        input logic signed [COORD_W-1:0] v,
        input logic [DIM_W-1:0]          n
    );
        logic [AXIS_W-1:0] c;
        if (v[COORD_W-1]) begin
            c = '0;
        end else if ($unsigned(v) >= COORD_W'(n)) begin
            c = AXIS_W'(n - DIM_MIN);
        end else begin
            c = v[AXIS_W-1:0];
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic [DIM_W-1:0]    r_cfg_x, r_cfg_y, r_cfg_z;
    logic [1:0]          r_cfg_wait;
    logic [NYZ_W-1:0]    r_nyz;
    logic [NCELL_W-1:0]  r_ncells;

    logic [NW-1:0]       r_loaded;
    logic [NW-1:0]       r_placed;
    logic                r_built;

    // Captured command.
    logic signed [COORD_W-1:0] r_x, r_y, r_z;
    logic                      r_skip;
    logic [POS_W-1:0]          r_pos;

    // Sequencer counters and running sum.
    logic [NW-1:0]       r_idx;
    logic [NCELL_W-1:0]  r_cell;
    logic [NW-1:0]       r_sum;

    // Staged result and output register.
    logic [STATUS_W-1:0] r_res_status;
    logic [VALUE_W-1:0]  r_res_a, r_res_b;
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_out_status;
    logic [VALUE_W-1:0]  r_out_a, r_out_b;

    // Stores. Each entry of the particle store holds the flat cell index with
    // the skip mark on top.
    logic [FLAT_W:0]     r_pcell_mem  [MAX_PARTICLES];
    logic [NW-1:0]       r_count_mem  [MAX_CELLS];
    logic [NW-1:0]       r_start_mem  [MAX_CELLS];
    logic [NW-1:0]       r_fill_mem   [MAX_CELLS];
    logic [PW-1:0]       r_sort_mem   [MAX_PARTICLES];

    logic [FLAT_W:0]     r_pc_q;
    logic [NW-1:0]       r_cnt_q;
    logic [NW-1:0]       r_start_q;
    logic [NW-1:0]       r_fill_q;
    logic [PW-1:0]       r_sort_q;

    // ------------------------------------------------------------------
    // Geometry and the shared index unit
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]    w_dx, w_dy, w_dz;
    logic [NCELL_W-1:0]  w_prod;
    logic [AXIS_W-1:0]   w_cx, w_cy, w_cz;
    logic [FLAT_W-1:0]   w_flat;
    logic [FLAT_W-1:0]   w_fit_in;
    logic [NCELL_W-1:0]  w_fit;

    assign w_dx   = dim_of(r_cfg_x);
    assign w_dy   = dim_of(r_cfg_y);
    assign w_dz   = dim_of(r_cfg_z);
    assign w_prod = NCELL_W'(w_dx) * NCELL_W'(r_nyz);

    assign w_cx   = clamp_coord(r_x, w_dx);
    assign w_cy   = clamp_coord(r_y, w_dy);
    assign w_cz   = clamp_coord(r_z, w_dz);
    // x*ny*nz + y*nz + z, with ny*nz held in a register.
    assign w_flat = FLAT_W'(NCELL_W'(w_cx) * NCELL_W'(r_nyz)
                          + NCELL_W'(w_cy) * NCELL_W'(w_dz)
                          + NCELL_W'(w_cz));

    // The fit unit maps an index beyond the cell total to the last cell. It
    // serves the read-cell lookup and both particle passes of a build.
    assign w_fit_in = (r_state == S_RDCELL) ? w_flat : r_pc_q[FLAT_W-1:0];
    assign w_fit    = ({1'b0, w_fit_in} >= r_ncells) ? (r_ncells - NCELL_W'(1))
                                                      : {1'b0, w_fit_in};

    logic w_accept, w_full, w_pos_bad, w_idx_end, w_cell_last, w_slot_free;

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_full      = (32'(r_loaded) >= MAX_PARTICLES);
    assign w_pos_bad   = (32'(r_pos) >= 32'(r_placed)) || (32'(r_pos) >= MAX_PARTICLES);
    assign w_idx_end   = (r_idx == r_loaded);
    assign w_cell_last = (r_cell == r_ncells - NCELL_W'(1));
    assign w_slot_free = !r_out_vld || o_out.ready;

    assign i_in.ready    = (r_state == S_IDLE) && (r_cfg_wait == 2'd0);
    assign o_out.valid   = r_out_vld;
    assign o_out.status  = r_out_status;
    assign o_out.value_a = r_out_a;
    assign o_out.value_b = r_out_b;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in.opcode)
                        OP_ADD:       n_state = S_ADD;
                        OP_BUILD:     n_state = S_ZERO;
                        OP_READ_CELL: n_state = S_RDCELL;
                        OP_READ_POS:  n_state = S_RDPOS;
                        default:      n_state = S_RESP;
                    endcase
                end
            end
            S_ADD:      n_state = S_RESP;
            S_RDCELL:   n_state = r_built ? S_RDCELL_W : S_RESP;
            S_RDCELL_W: n_state = S_RESP;
            S_RDPOS:    n_state = (r_built && !w_pos_bad) ? S_RDPOS_W : S_RESP;
            S_RDPOS_W:  n_state = S_RESP;
            S_ZERO:     n_state = w_cell_last ? S_CNT_RD : S_ZERO;
            S_CNT_RD:   n_state = w_idx_end ? S_PRE_RD : S_CNT_FIT;
            S_CNT_FIT:  n_state = r_pc_q[FLAT_W] ? S_CNT_RD : S_CNT_WR;
            S_CNT_WR:   n_state = S_CNT_RD;
            S_PRE_RD:   n_state = S_PRE_WR;
            S_PRE_WR:   n_state = w_cell_last ? S_SCT_RD : S_PRE_RD;
            S_SCT_RD:   n_state = w_idx_end ? S_BDONE : S_SCT_FIT;
            S_SCT_FIT:  n_state = r_pc_q[FLAT_W] ? S_SCT_RD : S_SCT_WR;
            S_SCT_WR:   n_state = S_SCT_RD;
            S_BDONE:    n_state = S_RESP;
            S_RESP:     n_state = w_slot_free ? S_IDLE : S_RESP;
            default:    n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: store controls
    // ------------------------------------------------------------------
    logic              w_pc_we, w_pc_re;
    logic              w_cnt_re, w_cnt_we;
    logic [CW-1:0]     w_cnt_raddr;
    logic [NW-1:0]     w_cnt_wdata;
    logic              w_start_re, w_start_we;
    logic              w_fill_re, w_fill_we;
    logic [NW-1:0]     w_fill_wdata;
    logic              w_sort_re, w_sort_we;

    always_comb begin
        w_pc_we      = 1'b0;
        w_pc_re      = 1'b0;
        w_cnt_re     = 1'b0;
        w_cnt_raddr  = CW'(w_fit);
        w_cnt_we     = 1'b0;
        w_cnt_wdata  = '0;
        w_start_re   = 1'b0;
        w_start_we   = 1'b0;
        w_fill_re    = 1'b0;
        w_fill_we    = 1'b0;
        w_fill_wdata = r_sum;
        w_sort_re    = 1'b0;
        w_sort_we    = 1'b0;
        unique case (r_state)
            S_ADD: begin
                w_pc_we = !w_full;
            end
            S_RDCELL: begin
                w_cnt_re   = r_built;
                w_start_re = r_built;
            end
            S_RDPOS: begin
                w_sort_re = r_built && !w_pos_bad;
            end
            S_ZERO: begin
                w_cnt_we = 1'b1;
            end
            S_CNT_RD, S_SCT_RD: begin
                w_pc_re = !w_idx_end;
            end
            S_CNT_FIT: begin
                w_cnt_re = !r_pc_q[FLAT_W];
            end
            S_CNT_WR: begin
                w_cnt_we    = 1'b1;
                w_cnt_wdata = r_cnt_q + NW'(1);
            end
            S_PRE_RD: begin
                w_cnt_re    = 1'b1;
                w_cnt_raddr = CW'(r_cell);
            end
            S_PRE_WR: begin
                w_start_we = 1'b1;
                w_fill_we  = 1'b1;
            end
            S_SCT_FIT: begin
                w_fill_re = !r_pc_q[FLAT_W];
            end
            S_SCT_WR: begin
                w_sort_we    = 1'b1;
                w_fill_we    = 1'b1;
                w_fill_wdata = r_fill_q + NW'(1);
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Stores
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_pc_we) begin
            r_pcell_mem[PW'(r_loaded)] <= {r_skip, w_flat};
        end
        if (w_pc_re) begin
            r_pc_q <= r_pcell_mem[PW'(r_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_count_mem[CW'(r_cell)] <= w_cnt_wdata;
        end
        if (w_cnt_re) begin
            r_cnt_q <= r_count_mem[w_cnt_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start_we) begin
            r_start_mem[CW'(r_cell)] <= r_sum;
        end
        if (w_start_re) begin
            r_start_q <= r_start_mem[CW'(w_fit)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fill_we) begin
            r_fill_mem[CW'(r_cell)] <= w_fill_wdata;
        end
        if (w_fill_re) begin
            r_fill_q <= r_fill_mem[CW'(w_fit)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sort_we) begin
            r_sort_mem[PW'(r_fill_q)] <= PW'(r_idx);
        end
        if (w_sort_re) begin
            r_sort_q <= r_sort_mem[PW'(r_pos)];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cfg_x    <= DIM_RESET;
            r_cfg_y    <= DIM_RESET;
            r_cfg_z    <= DIM_RESET;
            r_cfg_wait <= 2'd0;
            r_nyz      <= NYZ_W'(4);
            r_ncells   <= NCELL_W'(8);
            r_loaded   <= '0;
            r_placed   <= '0;
            r_built    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;

            // ny*nz and the cell total follow the registers one stage apart.
            r_nyz    <= NYZ_W'(w_dy) * NYZ_W'(w_dz);
            r_ncells <= (32'(w_prod) > MAX_CELLS) ? NCELL_W'(MAX_CELLS) : w_prod;

            if (i_cfg_we) begin
                r_cfg_wait <= CFG_SETTLE;
            end else if (r_cfg_wait != 2'd0) begin
                r_cfg_wait <= r_cfg_wait - 2'd1;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CELLS_X: begin
                        r_cfg_x <= i_cfg_wdata;
                        r_built <= 1'b0;
                    end
                    REG_CELLS_Y: begin
                        r_cfg_y <= i_cfg_wdata;
                        r_built <= 1'b0;
                    end
                    REG_CELLS_Z: begin
                        r_cfg_z <= i_cfg_wdata;
                        r_built <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            if (w_accept && i_in.opcode == OP_CLEAR) begin
                r_loaded <= '0;
                r_placed <= '0;
                r_built  <= 1'b0;
            end
            if (r_state == S_ADD && !w_full) begin
                r_loaded <= r_loaded + NW'(1);
                r_built  <= 1'b0;
            end
            if (r_state == S_BDONE) begin
                r_placed <= r_sum;
                r_built  <= 1'b1;
            end

            if (r_state == S_RESP && w_slot_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x          <= i_in.cell_x;
            r_y          <= i_in.cell_y;
            r_z          <= i_in.cell_z;
            r_skip       <= i_in.skip;
            r_pos        <= i_in.position;
            r_idx        <= '0;
            r_cell       <= '0;
            r_res_status <= ST_OK;
            r_res_a      <= '0;
            r_res_b      <= '0;
        end

        case (r_state)
            S_ADD: begin
                r_res_status <= w_full ? ST_FULL : ST_OK;
                r_res_a      <= w_full ? '0 : VALUE_W'(r_loaded);
            end
            S_RDCELL, S_RDPOS: begin
                if (!r_built) begin
                    r_res_status <= ST_NOT_BUILT;
                end else if (r_state == S_RDPOS && w_pos_bad) begin
                    r_res_status <= ST_RANGE;
                end
            end
            S_RDCELL_W: begin
                r_res_a <= VALUE_W'(r_start_q);
                r_res_b <= VALUE_W'(r_cnt_q);
            end
            S_RDPOS_W: begin
                r_res_a <= VALUE_W'(r_sort_q);
            end
            S_ZERO: begin
                r_cell <= r_cell + NCELL_W'(1);
            end
            S_CNT_RD: begin
                if (w_idx_end) begin
                    r_cell <= '0;
                    r_sum  <= '0;
                end
            end
            S_CNT_FIT, S_SCT_FIT: begin
                if (r_pc_q[FLAT_W]) begin
                    r_idx <= r_idx + NW'(1);
                end else begin
                    r_cell <= w_fit;
                end
            end
            S_CNT_WR, S_SCT_WR: begin
                r_idx <= r_idx + NW'(1);
            end
            S_PRE_WR: begin
                r_sum  <= r_sum + r_cnt_q;
                r_cell <= r_cell + NCELL_W'(1);
                if (w_cell_last) begin
                    r_idx <= '0;
                end
            end
            S_BDONE: begin
                r_res_a <= VALUE_W'(r_sum);
            end
            S_RESP: begin
                if (w_slot_free) begin
                    r_out_status <= r_res_status;
                    r_out_a      <= r_res_a;
                    r_out_b      <= r_res_b;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_loaded) <= MAX_PARTICLES)
        else $error("particle total beyond store depth");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("command taken while the sequencer is busy");

    a_cell_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNT_WR || r_state == S_PRE_WR || r_state == S_SCT_WR)
        |-> (r_cell < r_ncells))
        else $error("cell address beyond the cell total");

    a_placed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_built |-> (r_placed <= r_loaded))
        else $error("placed total exceeds loaded total");

    a_resp_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && r_out_vld && !o_out.ready) |=> (r_state == S_RESP))
        else $error("result register overwritten while occupied");

endmodule
`default_nettype wire
